>>> rtl/core/phd_pkg.sv
// phd_pkg: shared types and constants for the packet header deframer
// used by phd_parser, packet_header_deframer and phd_checker
`timescale 1ns / 1ps
`default_nettype none

package phd_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned COUNT_W   = 33;
    localparam int unsigned CFG_IDX_W = 3;

    // error codes, lowest nonzero wins
    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_SHORT    = 4'd1;
    localparam logic [3:0] ERR_MAGIC    = 4'd2;
    localparam logic [3:0] ERR_VERSION  = 4'd3;
    localparam logic [3:0] ERR_RESERVED = 4'd4;
    localparam logic [3:0] ERR_ZERO_SEQ = 4'd5;
    localparam logic [3:0] ERR_TOO_LONG = 4'd6;
    localparam logic [3:0] ERR_LEN_MISM = 4'd7;
    localparam logic [3:0] ERR_KIND     = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 3'd4;

    localparam logic [31:0] RST_MAGIC   = 32'h0000_0000;
    localparam logic [15:0] RST_VERSION = 16'd1;
    localparam logic [7:0]  RST_KIND_A  = 8'd1;
    localparam logic [7:0]  RST_KIND_B  = 8'd2;
    localparam logic [31:0] RST_MAX_LEN = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] protocol_version;
        logic [7:0]  kind_code_a;
        logic [7:0]  kind_code_b;
        logic [31:0] max_payload_bytes;
    } t_cfg;

    typedef struct packed {
        logic        emit;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        packet_done;
        logic        packet_ok;
        logic [3:0]  error_code;
        logic [7:0]  packet_kind;
        logic [31:0] sequence_number;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/packet_header_deframer.sv
// packet_header_deframer: byte-serial parser for a 16-byte header plus payload
// depends on phd_pkg and phd_parser
//
// usage
//   input channel: i_rx_byte / i_last_byte with i_in_valid, o_in_stall.
//   a request is taken at a clock edge with i_in_valid high and o_in_stall low.
//   output channel: o_out_valid, i_out_stall and the result fields; a result
//   is taken at an edge with o_out_valid high and i_out_stall low.
//   header bytes that are not last give no result. payload bytes come out with
//   o_payload_valid; the last byte carries the verdict (o_packet_done, ok,
//   error code, kind, sequence).
//   config: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index, i_cfg_data;
//   write only while no request is in flight. unknown indexes are ignored.
//   timing: one byte per cycle sustained while the output is not stalled. a
//   byte is parsed out of the input register and its result loads the output
//   register, which drives o_out_valid.
//   stall: while the output register holds a result and i_out_stall is high,
//   the input register holds its byte and o_in_stall goes high once it is full.
//   reset: synchronous, active low; clears both pipeline registers, the packet
//   state and loads the register defaults (magic 0, version 1, kinds 1 and 2,
//   max length all ones).
`timescale 1ns / 1ps
`default_nettype none

module packet_header_deframer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic                          i_last_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_payload_byte,
    output logic                               o_payload_valid,
    output logic                               o_packet_done,
    output logic                               o_packet_ok,
    output logic [3:0]                         o_error_code,
    output logic [7:0]                         o_packet_kind,
    output logic [31:0]                        o_sequence_number,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [phd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import phd_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid;
    logic [7:0] r_s1_byte;
    logic    r_s1_last;
    logic    r_out_valid;
    t_result r_res;
    t_result res;
    logic    s2_free;
    logic    step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word        <= RST_MAGIC;
            r_cfg.protocol_version  <= RST_VERSION;
            r_cfg.kind_code_a       <= RST_KIND_A;
            r_cfg.kind_code_b       <= RST_KIND_B;
            r_cfg.max_payload_bytes <= RST_MAX_LEN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_cfg.magic_word        <= i_cfg_data;
                CFG_VERSION: r_cfg.protocol_version  <= i_cfg_data[15:0];
                CFG_KIND_A:  r_cfg.kind_code_a       <= i_cfg_data[7:0];
                CFG_KIND_B:  r_cfg.kind_code_b       <= i_cfg_data[7:0];
                CFG_MAX_LEN: r_cfg.max_payload_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s2_free    = !r_out_valid || !i_out_stall;
    assign step       = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_byte <= i_rx_byte;
            r_s1_last <= i_last_byte;
        end
    end

    phd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_s1_valid && res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_byte    = r_res.payload_byte;
    assign o_payload_valid   = r_res.payload_valid;
    assign o_packet_done     = r_res.packet_done;
    assign o_packet_ok       = r_res.packet_ok;
    assign o_error_code      = r_res.error_code;
    assign o_packet_kind     = r_res.packet_kind;
    assign o_sequence_number = r_res.sequence_number;

endmodule

`default_nettype wire

>>> rtl/core/phd_parser.sv
// phd_parser: header field capture, payload count and verdict for one byte
// depends on phd_pkg
`timescale 1ns / 1ps
`default_nettype none

module phd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire phd_pkg::t_cfg   i_cfg,
    output phd_pkg::t_result     o_res
);
    import phd_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [POS_W-1:0]   r_pos,   n_pos,   u_pos;
    logic [31:0]        r_magic, n_magic, u_magic;
    logic [15:0]        r_ver,   n_ver,   u_ver;
    logic [7:0]         r_kind,  n_kind,  u_kind;
    logic               r_rsvd,  n_rsvd,  u_rsvd;
    logic [31:0]        r_seq,   n_seq,   u_seq;
    logic [31:0]        r_len,   n_len,   u_len;
    logic [COUNT_W-1:0] r_count, n_count, u_count;
    logic               is_pay;
    logic [3:0]         code;

    always_comb begin
        u_pos   = r_pos;
        u_magic = r_magic;
        u_ver   = r_ver;
        u_kind  = r_kind;
        u_rsvd  = r_rsvd;
        u_seq   = r_seq;
        u_len   = r_len;
        u_count = r_count;
        is_pay  = (r_pos >= POS_W'(HDR_BYTES));

        if (!is_pay) begin
            case (r_pos[3:0]) inside
                [4'd0:4'd3]:   u_magic = {r_magic[23:0], i_byte};
                [4'd4:4'd5]:   u_ver   = {r_ver[7:0], i_byte};
                4'd6:          u_kind  = i_byte;
                4'd7:          u_rsvd  = (i_byte != 8'd0);
                [4'd8:4'd11]:  u_seq   = {r_seq[23:0], i_byte};
                default:       u_len   = {r_len[23:0], i_byte};
            endcase
            u_pos = r_pos + POS_W'(1);
        end else if (r_count != COUNT_MAX) begin
            u_count = r_count + COUNT_W'(1);
        end

        // verdict on the state including this byte
        if (u_pos < POS_W'(HDR_BYTES))                     code = ERR_SHORT;
        else if (u_magic != i_cfg.magic_word)              code = ERR_MAGIC;
        else if (u_ver != i_cfg.protocol_version)          code = ERR_VERSION;
        else if (u_rsvd)                                   code = ERR_RESERVED;
        else if (u_seq == 32'd0)                           code = ERR_ZERO_SEQ;
        else if (u_len > i_cfg.max_payload_bytes)          code = ERR_TOO_LONG;
        else if ({1'b0, u_len} != u_count)                 code = ERR_LEN_MISM;
        else if (u_kind != i_cfg.kind_code_a && u_kind != i_cfg.kind_code_b)
                                                           code = ERR_KIND;
        else                                               code = ERR_OK;

        o_res                 = '0;
        o_res.emit            = is_pay || i_last;
        o_res.payload_valid   = is_pay;
        o_res.payload_byte    = is_pay ? i_byte : 8'd0;
        if (i_last) begin
            o_res.packet_done = 1'b1;
            o_res.packet_ok   = (code == ERR_OK);
            o_res.error_code  = code;
            if (code != ERR_SHORT) begin
                o_res.packet_kind     = u_kind;
                o_res.sequence_number = u_seq;
            end
        end

        // last byte returns the packet state to reset values
        if (i_last) begin
            n_pos   = '0;
            n_magic = '0;
            n_ver   = '0;
            n_kind  = '0;
            n_rsvd  = 1'b0;
            n_seq   = '0;
            n_len   = '0;
            n_count = '0;
        end else begin
            n_pos   = u_pos;
            n_magic = u_magic;
            n_ver   = u_ver;
            n_kind  = u_kind;
            n_rsvd  = u_rsvd;
            n_seq   = u_seq;
            n_len   = u_len;
            n_count = u_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_magic <= '0;
            r_ver   <= '0;
            r_kind  <= '0;
            r_rsvd  <= 1'b0;
            r_seq   <= '0;
            r_len   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_magic <= n_magic;
            r_ver   <= n_ver;
            r_kind  <= n_kind;
            r_rsvd  <= n_rsvd;
            r_seq   <= n_seq;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/phd_checker.sv
// phd_checker: port-level assertions for packet_header_deframer
// depends on phd_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module phd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  o_payload_byte,
    input  wire logic        o_payload_valid,
    input  wire logic        o_packet_done,
    input  wire logic        o_packet_ok,
    input  wire logic [3:0]  o_error_code,
    input  wire logic [7:0]  o_packet_kind,
    input  wire logic [31:0] o_sequence_number
);
    import phd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_payload_byte) && $stable(o_error_code))
        else $error("stalled result changed");

    // a result that is not a verdict is a bare payload byte
    a_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_done |->
            o_payload_valid && !o_packet_ok && o_error_code == ERR_OK
            && o_sequence_number == 32'd0)
        else $error("payload result carries verdict fields");

    // ok flag agrees with the error code
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_done |->
            (o_packet_ok == (o_error_code == ERR_OK)) && o_error_code <= ERR_KIND)
        else $error("ok flag and error code disagree");

    // a short packet ends inside the header
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_done && o_error_code == ERR_SHORT |->
            !o_payload_valid && o_packet_kind == 8'd0 && o_sequence_number == 32'd0)
        else $error("short packet verdict has payload or header fields");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind packet_header_deframer phd_checker u_phd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_payload_byte    (o_payload_byte),
    .o_payload_valid   (o_payload_valid),
    .o_packet_done     (o_packet_done),
    .o_packet_ok       (o_packet_ok),
    .o_error_code      (o_error_code),
    .o_packet_kind     (o_packet_kind),
    .o_sequence_number (o_sequence_number)
);

`default_nettype wire
